// ===== hdl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// Tag scanner package
// State codes, event bits, status codes and character classes for the
// markup tag scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

    localparam int unsigned CharWidth   = 21;
    localparam int unsigned EventWidth  = 19;
    localparam int unsigned StatusWidth = 2;

    typedef enum logic [5:0] {
        S_DEF = 6'd0, S_LT = 6'd1, S_ELEMENT = 6'd2, S_ELEMONLY = 6'd3,
        S_GT = 6'd4, S_EMPTYTAG = 6'd5, S_ATTS = 6'd6, S_NAME = 6'd7,
        S_VALUE = 6'd8, S_ATTS_OR_VALUE = 6'd9, S_INVALUE = 6'd10,
        S_SQ = 6'd11, S_DQ = 6'd12, S_INSQ = 6'd13, S_INDQ = 6'd14,
        S_ENDVALUE = 6'd15, S_MARKUP = 6'd16, S_UNKNOWN = 6'd17,
        S_SCRIPT = 6'd18, S_ENDSCRIPT = 6'd19,
        S_DT1 = 6'd20, S_DT2 = 6'd21, S_DT3 = 6'd22, S_DT4 = 6'd23,
        S_DT5 = 6'd24, S_DT6 = 6'd25, S_DT7 = 6'd26, S_DT8 = 6'd27,
        S_DT9 = 6'd28, S_DT10 = 6'd29,
        S_CD1 = 6'd30, S_CD2 = 6'd31, S_CD3 = 6'd32, S_CD4 = 6'd33,
        S_CD5 = 6'd34, S_CD6 = 6'd35, S_CD7 = 6'd36, S_CD8 = 6'd37,
        S_CD9 = 6'd38, S_H1 = 6'd39, S_H2 = 6'd40, S_H3 = 6'd41,
        S_ENDTAG = 6'd42
    } t_scan_state;

    typedef enum logic [1:0] {
        ST_NOTAG = 2'd0, ST_TAG = 2'd1, ST_END = 2'd2, ST_NEWTAG = 2'd3
    } t_status;

    localparam logic [18:0] EV_START_SCRIPT   = 19'h00001;
    localparam logic [18:0] EV_END_SCRIPT     = 19'h00002;
    localparam logic [18:0] EV_START_MARKUP   = 19'h00004;
    localparam logic [18:0] EV_END_MARKUP     = 19'h00008;
    localparam logic [18:0] EV_START_COMMENT  = 19'h00010;
    localparam logic [18:0] EV_END_COMMENT    = 19'h00020;
    localparam logic [18:0] EV_START_DOCTYPE  = 19'h00040;
    localparam logic [18:0] EV_END_DOCTYPE    = 19'h00080;
    localparam logic [18:0] EV_START_CDATA    = 19'h00100;
    localparam logic [18:0] EV_END_CDATA      = 19'h00200;
    localparam logic [18:0] EV_START_ELEM     = 19'h00400;
    localparam logic [18:0] EV_END_ELEM       = 19'h00800;
    localparam logic [18:0] EV_START_ATTNAME  = 19'h01000;
    localparam logic [18:0] EV_END_ATTNAME    = 19'h02000;
    localparam logic [18:0] EV_START_VALUE    = 19'h04000;
    localparam logic [18:0] EV_END_VALUE      = 19'h08000;
    localparam logic [18:0] EV_END_TAG        = 19'h10000;
    localparam logic [18:0] EV_EMPTY_TAG      = 19'h20000;
    localparam logic [18:0] EV_NO_MORE_ATTS   = 19'h40000;

    // Character classes decoded once per character.
    typedef struct packed {
        logic lt;
        logic gt;
        logic bang;
        logic quest;
        logic slash;
        logic eq;
        logic lsq;
        logic rsq;
        logic dash;
        logic squote;
        logic dquote;
        logic ws;
        logic ws4;
        logic alpha;
        logic alnum;
        logic punct;
        logic kw_match;
    } t_char_class;

    // Expected letter of the DOCTYPE or CDATA keyword for a keyword state.
    // In the markup state the expected letter is the 'D' that opens DOCTYPE.
    function automatic logic [20:0] keyword_letter(input logic [5:0] s);
        logic [20:0] l;
        unique case (s)
            S_MARKUP: l = 21'h44;
            S_DT1:   l = 21'h4F;
            S_DT2:   l = 21'h43;
            S_DT3:   l = 21'h54;
            S_DT4:   l = 21'h59;
            S_DT5:   l = 21'h50;
            S_DT6:   l = 21'h45;
            S_CD1:   l = 21'h43;
            S_CD2:   l = 21'h44;
            S_CD3:   l = 21'h41;
            S_CD4:   l = 21'h54;
            S_CD5:   l = 21'h41;
            default: l = 21'h1FFFFF;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sts_stream_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one request with a payload of parameterised width.
// ----------------------------------------------------------------------------
`default_nettype none

interface sts_stream_if #(
    parameter int unsigned Width = 8
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/sgml_tag_scanner_top.sv =====
// ----------------------------------------------------------------------------
// Markup tag scanner
// One character in, one status and event mask out per character.
//
// Usage: characters arrive on the input stream (21-bit code point) and one
// result per character leaves on the output stream: a 2-bit tag status and
// a 19-bit event mask. A request is accepted when valid and ready are high.
// The character is decoded against the scanner state in the same cycle as
// it is accepted and the result is registered. The scanner takes one
// character per clock while input ready is high. The output register has
// a skid stage behind it, so input ready stays high while one result waits
// and is withdrawn only when both are full. At reset the scanner returns to
// the outside-tag state and both output slots are emptied. While the receiver
// stalls, results are held in order and no character is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module sgml_tag_scanner_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sts_stream_if.sink   i_char,
    sts_stream_if.source o_result
);
    localparam int unsigned ResW = sts_pkg::StatusWidth + sts_pkg::EventWidth;

    logic [5:0]  r_state, n_state;
    logic [1:0]  status;
    logic [18:0] events;
    sts_pkg::t_char_class cls;

    logic            r_out_valid, r_skid_valid;
    logic [ResW-1:0] r_out_data, r_skid_data;
    logic            accept, take;

    sts_classify u_classify (
        .i_char  (i_char.data[sts_pkg::CharWidth-1:0]),
        .i_state (r_state),
        .o_class (cls)
    );

    sts_next_state u_next (
        .i_state  (r_state),
        .i_class  (cls),
        .o_next   (n_state),
        .o_status (status),
        .o_events (events)
    );

    assign i_char.ready   = !r_skid_valid;
    assign accept         = i_char.valid && i_char.ready;
    assign take           = o_result.valid && o_result.ready;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    // Scanner state advances on every accepted character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= sts_pkg::S_DEF;
        else if (accept) r_state <= n_state;
    end

    // Output register with skid stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || take) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                    if (accept) r_out_data <= {status, events};
                end
            end else if (accept) begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= {status, events};
            end
        end
    end

    // A waiting skid entry implies the output slot is full.
    a_skid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid) else $error("skid holds data, output empty");
    // State codes beyond the last state are never reached.
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state <= sts_pkg::S_ENDTAG) else $error("scanner state out of range");
    // After an accepted character the output slot is always full next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid) else $error("accepted character lost");
endmodule

`default_nettype wire

// ===== hdl/sts_classify.sv =====
// ----------------------------------------------------------------------------
// Character classifier
// Decodes one character into the classes used by the state transitions.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_classify (
    input  wire logic [20:0]               i_char,
    input  wire logic [5:0]                i_state,
    output sts_pkg::t_char_class           o_class
);
    logic upper, lower, digit;

    // Plain comparisons on the character code.
    always_comb begin
        upper = (i_char >= 21'h41) && (i_char <= 21'h5A);
        lower = (i_char >= 21'h61) && (i_char <= 21'h7A);
        digit = (i_char >= 21'h30) && (i_char <= 21'h39);
        o_class.lt     = (i_char == 21'h3C);
        o_class.gt     = (i_char == 21'h3E);
        o_class.bang   = (i_char == 21'h21);
        o_class.quest  = (i_char == 21'h3F);
        o_class.slash  = (i_char == 21'h2F);
        o_class.eq     = (i_char == 21'h3D);
        o_class.lsq    = (i_char == 21'h5B);
        o_class.rsq    = (i_char == 21'h5D);
        o_class.dash   = (i_char == 21'h2D);
        o_class.squote = (i_char == 21'h27);
        o_class.dquote = (i_char == 21'h22);
        o_class.ws4    = (i_char == 21'h20) || (i_char == 21'h09) ||
                         (i_char == 21'h0A) || (i_char == 21'h0D);
        o_class.ws     = o_class.ws4 || (i_char == 21'hA0);
        o_class.alpha  = upper || lower || i_char[7];
        o_class.alnum  = o_class.alpha || digit;
        o_class.punct  = o_class.dash || (i_char == 21'h5F) ||
                         (i_char == 21'h3A) || (i_char == 21'h2E);
        o_class.kw_match = (i_char == sts_pkg::keyword_letter(i_state));
    end
endmodule

`default_nettype wire

// ===== hdl/sts_next_state.sv =====
// ----------------------------------------------------------------------------
// Scanner transition logic
// Gives next state, tag status and events for one classified character.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_next_state (
    input  wire logic [5:0]           i_state,
    input  wire sts_pkg::t_char_class i_class,
    output logic [5:0]                o_next,
    output logic [1:0]                o_status,
    output logic [18:0]               o_events
);
    sts_pkg::t_char_class c;
    logic [5:0] s;

    always_comb begin
        c = i_class;
        s = (i_state > sts_pkg::S_ENDTAG) ? sts_pkg::S_DEF : i_state;
        o_next   = s;
        o_events = '0;
        o_status = sts_pkg::ST_TAG;
        unique case (s)
            sts_pkg::S_DEF: begin
                if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_events = sts_pkg::EV_START_MARKUP;
                end else o_status = sts_pkg::ST_NOTAG;
            end
            sts_pkg::S_LT: begin
                priority if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end else if (c.bang) o_next = sts_pkg::S_MARKUP;
                else if (c.quest) begin
                    o_next = sts_pkg::S_SCRIPT; o_events = sts_pkg::EV_START_SCRIPT;
                end else if (c.slash) begin
                    o_next = sts_pkg::S_ENDTAG; o_events = sts_pkg::EV_END_TAG;
                end else if (c.ws) begin
                end else if (c.alpha) begin
                    o_next = sts_pkg::S_ELEMENT; o_events = sts_pkg::EV_START_ELEM;
                end else begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end
            end
            sts_pkg::S_ELEMENT, sts_pkg::S_ELEMONLY: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_END_ELEM | sts_pkg::EV_NO_MORE_ATTS |
                               sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = sts_pkg::EV_END_ELEM | sts_pkg::EV_NO_MORE_ATTS;
                end else if (c.punct) begin
                end else if (c.ws) begin
                    o_next = (s == sts_pkg::S_ELEMENT) ? sts_pkg::S_ATTS : sts_pkg::S_GT;
                    o_events = sts_pkg::EV_END_ELEM;
                end else if (c.slash && s == sts_pkg::S_ELEMENT) begin
                    o_next = sts_pkg::S_EMPTYTAG;
                    o_events = sts_pkg::EV_END_ELEM | sts_pkg::EV_EMPTY_TAG |
                               sts_pkg::EV_NO_MORE_ATTS;
                end else if (c.alnum) begin
                end else begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end
            end
            sts_pkg::S_GT, sts_pkg::S_EMPTYTAG: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_START_MARKUP |
                        ((s == sts_pkg::S_GT) ? sts_pkg::EV_NO_MORE_ATTS : '0);
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = (s == sts_pkg::S_GT) ? sts_pkg::EV_NO_MORE_ATTS : '0;
                end else if (c.ws) begin
                end else begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end
            end
            sts_pkg::S_ATTS, sts_pkg::S_ENDTAG: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_NO_MORE_ATTS | sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = sts_pkg::EV_NO_MORE_ATTS;
                end else if (c.ws) begin
                end else if (c.slash && s == sts_pkg::S_ATTS) begin
                    o_next = sts_pkg::S_EMPTYTAG;
                    o_events = sts_pkg::EV_EMPTY_TAG | sts_pkg::EV_NO_MORE_ATTS;
                end else if (c.alpha) begin
                    o_next = (s == sts_pkg::S_ATTS) ? sts_pkg::S_NAME : sts_pkg::S_ELEMONLY;
                    o_events = (s == sts_pkg::S_ATTS) ? sts_pkg::EV_START_ATTNAME
                                                      : sts_pkg::EV_START_ELEM;
                end else begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end
            end
            sts_pkg::S_NAME: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_END_ATTNAME | sts_pkg::EV_NO_MORE_ATTS |
                               sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = sts_pkg::EV_END_ATTNAME | sts_pkg::EV_NO_MORE_ATTS;
                end else if (c.punct) begin
                end else if (c.ws) begin
                    o_next = sts_pkg::S_ATTS_OR_VALUE; o_events = sts_pkg::EV_END_ATTNAME;
                end else if (c.slash) begin
                    o_next = sts_pkg::S_EMPTYTAG;
                    o_events = sts_pkg::EV_END_ATTNAME | sts_pkg::EV_EMPTY_TAG;
                end else if (c.eq) begin
                    o_next = sts_pkg::S_VALUE; o_events = sts_pkg::EV_END_ATTNAME;
                end else if (c.alnum) begin
                end else begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end
            end
            sts_pkg::S_VALUE: begin
                priority if (c.gt || c.slash || c.eq) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end else if (c.ws) begin
                end else if (c.squote) o_next = sts_pkg::S_SQ;
                else if (c.dquote) o_next = sts_pkg::S_DQ;
                else if (c.alnum) begin
                    o_next = sts_pkg::S_INVALUE; o_events = sts_pkg::EV_START_VALUE;
                end else begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end
            end
            sts_pkg::S_ATTS_OR_VALUE: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_NO_MORE_ATTS | sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = sts_pkg::EV_NO_MORE_ATTS;
                end else if (c.punct) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end else if (c.ws) begin
                end else if (c.slash) begin
                    o_next = sts_pkg::S_EMPTYTAG;
                    o_events = sts_pkg::EV_EMPTY_TAG | sts_pkg::EV_NO_MORE_ATTS;
                end else if (c.eq) o_next = sts_pkg::S_VALUE;
                else if (c.alpha) begin
                    o_next = sts_pkg::S_NAME; o_events = sts_pkg::EV_START_ATTNAME;
                end else begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end
            end
            sts_pkg::S_INVALUE: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_END_VALUE | sts_pkg::EV_NO_MORE_ATTS |
                               sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = sts_pkg::EV_END_VALUE | sts_pkg::EV_NO_MORE_ATTS;
                end else if (c.ws) begin
                    o_next = sts_pkg::S_ATTS; o_events = sts_pkg::EV_END_VALUE;
                end else if (c.alnum) begin
                end else begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end
            end
            sts_pkg::S_SQ, sts_pkg::S_DQ: begin
                if ((s == sts_pkg::S_SQ) ? c.squote : c.dquote) begin
                    o_next = sts_pkg::S_ENDVALUE;
                    o_events = sts_pkg::EV_START_VALUE | sts_pkg::EV_END_VALUE;
                end else begin
                    o_next = (s == sts_pkg::S_SQ) ? sts_pkg::S_INSQ : sts_pkg::S_INDQ;
                    o_events = sts_pkg::EV_START_VALUE;
                end
            end
            sts_pkg::S_INSQ, sts_pkg::S_INDQ: begin
                if ((s == sts_pkg::S_INSQ) ? c.squote : c.dquote) begin
                    o_next = sts_pkg::S_ENDVALUE; o_events = sts_pkg::EV_END_VALUE;
                end
            end
            sts_pkg::S_ENDVALUE: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_NO_MORE_ATTS | sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = sts_pkg::EV_NO_MORE_ATTS;
                end else if (c.ws) o_next = sts_pkg::S_ATTS;
                else if (c.slash) begin
                    o_next = sts_pkg::S_EMPTYTAG;
                    o_events = sts_pkg::EV_EMPTY_TAG | sts_pkg::EV_NO_MORE_ATTS;
                end else begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end
            end
            sts_pkg::S_MARKUP, sts_pkg::S_UNKNOWN: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_END_MARKUP | sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = sts_pkg::EV_END_MARKUP;
                end else if (s == sts_pkg::S_UNKNOWN) begin
                end else if (c.dash) o_next = sts_pkg::S_H1;
                else if (c.lsq) o_next = sts_pkg::S_CD1;
                else if (c.kw_match) o_next = sts_pkg::S_DT1;
                else o_next = sts_pkg::S_UNKNOWN;
            end
            sts_pkg::S_SCRIPT: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_END_SCRIPT | sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = sts_pkg::EV_END_SCRIPT;
                end else if (c.quest) o_next = sts_pkg::S_ENDSCRIPT;
                else begin
                end
            end
            sts_pkg::S_ENDSCRIPT: begin
                if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = sts_pkg::EV_END_SCRIPT;
                end else if (!c.quest) o_next = sts_pkg::S_SCRIPT;
            end
            sts_pkg::S_DT7, sts_pkg::S_DT8, sts_pkg::S_DT10: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = sts_pkg::EV_END_DOCTYPE;
                end else if (s == sts_pkg::S_DT8) begin
                    if (c.lsq) o_next = sts_pkg::S_DT9;
                end else if (c.ws4) begin
                    if (s == sts_pkg::S_DT7) begin
                        o_next = sts_pkg::S_DT8; o_events = sts_pkg::EV_START_DOCTYPE;
                    end
                end else begin
                    o_next = (s == sts_pkg::S_DT7) ? sts_pkg::S_UNKNOWN : sts_pkg::S_MARKUP;
                end
            end
            sts_pkg::S_DT9: begin
                if (c.rsq) o_next = sts_pkg::S_DT10;
            end
            sts_pkg::S_CD6: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                end else if (c.lsq) begin
                    o_next = sts_pkg::S_CD7; o_events = sts_pkg::EV_START_CDATA;
                end else o_next = sts_pkg::S_MARKUP;
            end
            sts_pkg::S_CD7: begin
                if (c.rsq) o_next = sts_pkg::S_CD8;
            end
            sts_pkg::S_CD8: begin
                o_next = c.rsq ? sts_pkg::S_CD9 : sts_pkg::S_CD7;
            end
            sts_pkg::S_CD9: begin
                if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                    o_events = sts_pkg::EV_END_CDATA;
                end else if (!c.rsq) o_next = sts_pkg::S_CD7;
            end
            sts_pkg::S_H1: begin
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NOTAG;
                    o_events = sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_NOTAG;
                end else if (c.dash) begin
                    o_next = sts_pkg::S_H2; o_events = sts_pkg::EV_START_COMMENT;
                end else o_next = sts_pkg::S_UNKNOWN;
            end
            sts_pkg::S_H2: begin
                if (c.dash) o_next = sts_pkg::S_H3;
            end
            sts_pkg::S_H3: begin
                if (c.dash) begin
                    o_next = sts_pkg::S_MARKUP; o_events = sts_pkg::EV_END_COMMENT;
                end else o_next = sts_pkg::S_H2;
            end
            default: begin
                // Keyword letters of DOCTYPE and CDATA.
                priority if (c.lt) begin
                    o_next = sts_pkg::S_LT; o_status = sts_pkg::ST_NEWTAG;
                    o_events = sts_pkg::EV_START_MARKUP;
                end else if (c.gt) begin
                    o_next = sts_pkg::S_DEF; o_status = sts_pkg::ST_END;
                end else if (c.kw_match) o_next = s + 6'd1;
                else o_next = sts_pkg::S_MARKUP;
            end
        endcase
    end
endmodule

`default_nettype wire

// ===== test/sgml_tag_scanner_top_tb.sv =====
// ----------------------------------------------------------------------------
// Markup tag scanner testbench
// Feeds characters into the tag scanner: first a short table of directed
// characters, then random markup fragments with noise. Each accepted
// character is run through a local model of the scanner state machine, and
// every result is compared with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module sgml_tag_scanner_top_tb;

    localparam int HalfPeriod  = 6;
    localparam int ResetCycles = 9;
    localparam int IdleLimit   = 3000;
    localparam int HoldCycles  = 200;
    localparam int ItemsPerPhase = 650;

    typedef struct packed {
        logic [1:0]  status;
        logic [18:0] events;
    } t_scan_result;

    typedef struct {
        logic [20:0]  ch;
        bit           typed;
        t_scan_result res;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sts_stream_if #(.Width(sts_pkg::CharWidth)) char_if();
    sts_stream_if #(.Width(sts_pkg::StatusWidth + sts_pkg::EventWidth)) result_if();

    sgml_tag_scanner_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_if.sink),
        .o_result (result_if.source)
    );

    always #HalfPeriod i_clk = ~i_clk;

    logic [20:0]  char_feed[$];
    t_scan_result expected_results[$];
    logic [5:0]   model_state;
    int           error_count = 0;
    int           phase = 0;
    int           send_idle_pct = 28;
    int           recv_idle_pct = 58;
    int           quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------
    function automatic bit is_ws4(input logic [20:0] c);
        return c == " " || c == 21'h09 || c == 21'h0A || c == 21'h0D;
    endfunction

    function automatic bit is_ws(input logic [20:0] c);
        return is_ws4(c) || c == 21'hA0;
    endfunction

    function automatic bit is_alpha(input logic [20:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c[7];
    endfunction

    function automatic bit is_alnum(input logic [20:0] c);
        return is_alpha(c) || (c >= "0" && c <= "9");
    endfunction

    function automatic bit is_punct(input logic [20:0] c);
        return c == "-" || c == "_" || c == ":" || c == ".";
    endfunction

    // '<' closes the tag and opens another, '>' closes it.
    function automatic bit tag_close(input logic [20:0] c, input logic [18:0] extra,
                                     inout logic [5:0] nx, inout logic [1:0] st,
                                     inout logic [18:0] ev);
        if (c == "<") begin
            nx = sts_pkg::S_LT; ev |= extra | sts_pkg::EV_START_MARKUP;
            st = sts_pkg::ST_NEWTAG;
            return 1'b1;
        end
        if (c == ">") begin
            nx = sts_pkg::S_DEF; ev |= extra; st = sts_pkg::ST_END;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_scan_result scan_char(input logic [20:0] c, inout logic [5:0] cur);
        logic [5:0]  s;
        logic [5:0]  nx;
        logic [1:0]  st;
        logic [18:0] ev;
        string       dt_word;
        string       cd_word;
        t_scan_result r;
        dt_word = "OCTYPE";
        cd_word = "CDATA";
        s  = (cur > sts_pkg::S_ENDTAG) ? sts_pkg::S_DEF : cur;
        nx = s;
        ev = '0;
        st = sts_pkg::ST_TAG;
        case (sts_pkg::t_scan_state'(s))
            sts_pkg::S_DEF: begin
                if (c == "<") begin nx = sts_pkg::S_LT; ev |= sts_pkg::EV_START_MARKUP; end
                else st = sts_pkg::ST_NOTAG;
            end
            sts_pkg::S_LT: begin
                if (c == ">") begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
                else if (c == "!") nx = sts_pkg::S_MARKUP;
                else if (c == "?") begin
                    nx = sts_pkg::S_SCRIPT; ev |= sts_pkg::EV_START_SCRIPT;
                end else if (c == "/") begin
                    nx = sts_pkg::S_ENDTAG; ev |= sts_pkg::EV_END_TAG;
                end else if (is_ws(c)) ;
                else if (is_alpha(c)) begin
                    nx = sts_pkg::S_ELEMENT; ev |= sts_pkg::EV_START_ELEM;
                end else begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
            end
            sts_pkg::S_ELEMENT, sts_pkg::S_ELEMONLY: begin
                if (tag_close(c, sts_pkg::EV_END_ELEM | sts_pkg::EV_NO_MORE_ATTS,
                              nx, st, ev)) ;
                else if (is_punct(c)) ;
                else if (is_ws(c)) begin
                    nx = (s == sts_pkg::S_ELEMENT) ? sts_pkg::S_ATTS : sts_pkg::S_GT;
                    ev |= sts_pkg::EV_END_ELEM;
                end else if (c == "/" && s == sts_pkg::S_ELEMENT) begin
                    nx = sts_pkg::S_EMPTYTAG;
                    ev |= sts_pkg::EV_END_ELEM | sts_pkg::EV_EMPTY_TAG |
                          sts_pkg::EV_NO_MORE_ATTS;
                end else if (is_alnum(c)) ;
                else begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
            end
            sts_pkg::S_GT, sts_pkg::S_EMPTYTAG: begin
                if (tag_close(c, (s == sts_pkg::S_GT) ? sts_pkg::EV_NO_MORE_ATTS : '0,
                              nx, st, ev)) ;
                else if (is_ws(c)) ;
                else begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
            end
            sts_pkg::S_ATTS, sts_pkg::S_ENDTAG: begin
                if (tag_close(c, sts_pkg::EV_NO_MORE_ATTS, nx, st, ev)) ;
                else if (is_ws(c)) ;
                else if (c == "/" && s == sts_pkg::S_ATTS) begin
                    nx = sts_pkg::S_EMPTYTAG;
                    ev |= sts_pkg::EV_EMPTY_TAG | sts_pkg::EV_NO_MORE_ATTS;
                end else if (is_alpha(c)) begin
                    nx = (s == sts_pkg::S_ATTS) ? sts_pkg::S_NAME : sts_pkg::S_ELEMONLY;
                    ev |= (s == sts_pkg::S_ATTS) ? sts_pkg::EV_START_ATTNAME
                                                 : sts_pkg::EV_START_ELEM;
                end else begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
            end
            sts_pkg::S_NAME: begin
                if (tag_close(c, sts_pkg::EV_END_ATTNAME | sts_pkg::EV_NO_MORE_ATTS,
                              nx, st, ev)) ;
                else if (is_punct(c)) ;
                else if (is_ws(c)) begin
                    nx = sts_pkg::S_ATTS_OR_VALUE; ev |= sts_pkg::EV_END_ATTNAME;
                end else if (c == "/") begin
                    nx = sts_pkg::S_EMPTYTAG;
                    ev |= sts_pkg::EV_END_ATTNAME | sts_pkg::EV_EMPTY_TAG;
                end else if (c == "=") begin
                    nx = sts_pkg::S_VALUE; ev |= sts_pkg::EV_END_ATTNAME;
                end else if (is_alnum(c)) ;
                else begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
            end
            sts_pkg::S_VALUE: begin
                if (c == ">" || c == "/" || c == "=") begin
                    nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG;
                end else if (is_ws(c)) ;
                else if (c == "'") nx = sts_pkg::S_SQ;
                else if (c == "\"") nx = sts_pkg::S_DQ;
                else if (is_alnum(c)) begin
                    nx = sts_pkg::S_INVALUE; ev |= sts_pkg::EV_START_VALUE;
                end else begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
            end
            sts_pkg::S_ATTS_OR_VALUE: begin
                if (tag_close(c, sts_pkg::EV_NO_MORE_ATTS, nx, st, ev)) ;
                else if (is_punct(c)) begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
                else if (is_ws(c)) ;
                else if (c == "/") begin
                    nx = sts_pkg::S_EMPTYTAG;
                    ev |= sts_pkg::EV_EMPTY_TAG | sts_pkg::EV_NO_MORE_ATTS;
                end else if (c == "=") nx = sts_pkg::S_VALUE;
                else if (is_alpha(c)) begin
                    nx = sts_pkg::S_NAME; ev |= sts_pkg::EV_START_ATTNAME;
                end else begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
            end
            sts_pkg::S_INVALUE: begin
                if (tag_close(c, sts_pkg::EV_END_VALUE | sts_pkg::EV_NO_MORE_ATTS,
                              nx, st, ev)) ;
                else if (is_ws(c)) begin
                    nx = sts_pkg::S_ATTS; ev |= sts_pkg::EV_END_VALUE;
                end else if (is_alnum(c)) ;
                else begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
            end
            // The first character after an opening quote always starts the value.
            sts_pkg::S_SQ, sts_pkg::S_DQ: begin
                ev |= sts_pkg::EV_START_VALUE;
                if (c == ((s == sts_pkg::S_SQ) ? 21'("'") : 21'("\""))) begin
                    nx = sts_pkg::S_ENDVALUE; ev |= sts_pkg::EV_END_VALUE;
                end else nx = (s == sts_pkg::S_SQ) ? sts_pkg::S_INSQ : sts_pkg::S_INDQ;
            end
            sts_pkg::S_INSQ, sts_pkg::S_INDQ: begin
                if (c == ((s == sts_pkg::S_INSQ) ? 21'("'") : 21'("\""))) begin
                    nx = sts_pkg::S_ENDVALUE; ev |= sts_pkg::EV_END_VALUE;
                end
            end
            sts_pkg::S_ENDVALUE: begin
                if (tag_close(c, sts_pkg::EV_NO_MORE_ATTS, nx, st, ev)) ;
                else if (is_ws(c)) nx = sts_pkg::S_ATTS;
                else if (c == "/") begin
                    nx = sts_pkg::S_EMPTYTAG;
                    ev |= sts_pkg::EV_EMPTY_TAG | sts_pkg::EV_NO_MORE_ATTS;
                end else begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
            end
            sts_pkg::S_MARKUP: begin
                if (tag_close(c, sts_pkg::EV_END_MARKUP, nx, st, ev)) ;
                else if (c == "-") nx = sts_pkg::S_H1;
                else if (c == "[") nx = sts_pkg::S_CD1;
                else if (c == "D") nx = sts_pkg::S_DT1;
                else nx = sts_pkg::S_UNKNOWN;
            end
            sts_pkg::S_UNKNOWN: void'(tag_close(c, sts_pkg::EV_END_MARKUP, nx, st, ev));
            sts_pkg::S_SCRIPT: begin
                if (tag_close(c, sts_pkg::EV_END_SCRIPT, nx, st, ev)) ;
                else if (c == "?") nx = sts_pkg::S_ENDSCRIPT;
            end
            sts_pkg::S_ENDSCRIPT: begin
                if (c == ">") begin
                    nx = sts_pkg::S_DEF; ev |= sts_pkg::EV_END_SCRIPT; st = sts_pkg::ST_END;
                end else if (c != "?") nx = sts_pkg::S_SCRIPT;
            end
            sts_pkg::S_DT7: begin
                if (tag_close(c, (c == ">") ? sts_pkg::EV_END_DOCTYPE : '0, nx, st, ev)) ;
                else if (is_ws4(c)) begin
                    nx = sts_pkg::S_DT8; ev |= sts_pkg::EV_START_DOCTYPE;
                end else nx = sts_pkg::S_UNKNOWN;
            end
            sts_pkg::S_DT8: begin
                if (tag_close(c, (c == ">") ? sts_pkg::EV_END_DOCTYPE : '0, nx, st, ev)) ;
                else if (c == "[") nx = sts_pkg::S_DT9;
            end
            sts_pkg::S_DT9: if (c == "]") nx = sts_pkg::S_DT10;
            sts_pkg::S_DT10: begin
                if (tag_close(c, (c == ">") ? sts_pkg::EV_END_DOCTYPE : '0, nx, st, ev)) ;
                else if (is_ws4(c)) ;
                else nx = sts_pkg::S_MARKUP;
            end
            sts_pkg::S_CD6: begin
                if (tag_close(c, '0, nx, st, ev)) ;
                else if (c == "[") begin
                    nx = sts_pkg::S_CD7; ev |= sts_pkg::EV_START_CDATA;
                end else nx = sts_pkg::S_MARKUP;
            end
            sts_pkg::S_CD7: if (c == "]") nx = sts_pkg::S_CD8;
            sts_pkg::S_CD8: nx = (c == "]") ? sts_pkg::S_CD9 : sts_pkg::S_CD7;
            sts_pkg::S_CD9: begin
                if (c == ">") begin
                    nx = sts_pkg::S_DEF; ev |= sts_pkg::EV_END_CDATA; st = sts_pkg::ST_END;
                end else if (c != "]") nx = sts_pkg::S_CD7;
            end
            // After "<!-" a '<' reopens a tag yet reports outside-tag status.
            sts_pkg::S_H1: begin
                if (c == "<") begin
                    nx = sts_pkg::S_LT; ev |= sts_pkg::EV_START_MARKUP;
                    st = sts_pkg::ST_NOTAG;
                end else if (c == ">") begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
                else if (c == "-") begin
                    nx = sts_pkg::S_H2; ev |= sts_pkg::EV_START_COMMENT;
                end else nx = sts_pkg::S_UNKNOWN;
            end
            sts_pkg::S_H2: if (c == "-") nx = sts_pkg::S_H3;
            sts_pkg::S_H3: begin
                if (c == "-") begin
                    nx = sts_pkg::S_MARKUP; ev |= sts_pkg::EV_END_COMMENT;
                end else nx = sts_pkg::S_H2;
            end
            // Keyword letters of DOCTYPE and CDATA.
            default: begin
                if (tag_close(c, '0, nx, st, ev)) ;
                else if (s >= sts_pkg::S_DT1 && s < sts_pkg::S_DT7) begin
                    nx = (c == 21'(dt_word[s - sts_pkg::S_DT1])) ? s + 6'd1
                                                                 : sts_pkg::S_MARKUP;
                end else if (s >= sts_pkg::S_CD1 && s < sts_pkg::S_CD6) begin
                    nx = (c == 21'(cd_word[s - sts_pkg::S_CD1])) ? s + 6'd1
                                                                 : sts_pkg::S_MARKUP;
                end else begin nx = sts_pkg::S_DEF; st = sts_pkg::ST_NOTAG; end
            end
        endcase
        cur = nx;
        r.status = st;
        r.events = ev;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table: typed results only where they are obvious.
    // ------------------------------------------------------------------
    t_directed_row directed_rows[25] = '{
        '{21'h41,     1'b1, '{sts_pkg::ST_NOTAG, '0}},
        '{21'h1FFFFF, 1'b1, '{sts_pkg::ST_NOTAG, '0}},
        '{21'h000000, 1'b1, '{sts_pkg::ST_NOTAG, '0}},
        '{"<",        1'b1, '{sts_pkg::ST_TAG, sts_pkg::EV_START_MARKUP}},
        '{"!",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{"-",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{"<",        1'b1, '{sts_pkg::ST_NOTAG, sts_pkg::EV_START_MARKUP}},
        '{">",        1'b1, '{sts_pkg::ST_NOTAG, '0}},
        '{"<",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{"?",        1'b1, '{sts_pkg::ST_TAG, sts_pkg::EV_START_SCRIPT}},
        '{"?",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{"x",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{"?",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{"?",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{">",        1'b1, '{sts_pkg::ST_END, sts_pkg::EV_END_SCRIPT}},
        '{"<",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{21'h100080, 1'b1, '{sts_pkg::ST_TAG, sts_pkg::EV_START_ELEM}},
        '{21'hA0,     1'b1, '{sts_pkg::ST_TAG, sts_pkg::EV_END_ELEM}},
        '{"b",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{"=",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{"'",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{"'",        1'b1, '{sts_pkg::ST_TAG,
                              sts_pkg::EV_START_VALUE | sts_pkg::EV_END_VALUE}},
        '{"/",        1'b0, '{sts_pkg::ST_NOTAG, '0}},
        '{"<",        1'b1, '{sts_pkg::ST_NEWTAG, sts_pkg::EV_START_MARKUP}},
        '{"/",        1'b1, '{sts_pkg::ST_TAG, sts_pkg::EV_END_TAG}}
    };
    bit directed_typed[$];
    t_scan_result directed_res[$];

    string fragments[17] = '{
        "<a href=\"x y\">", "<p>", "</div >", "<br/>", "<img src='a' alt=b />",
        "<!DOCTYPE html>", "<!DOCTYPE x [<!ENTITY a>]\t>", "<![CDATA[ab]]]>",
        "<!-- note -- -->", "<?xml v='1'??>", "<x a b = c d=\"\">", "<!x>",
        "<a:b-c.d e_f=1>", "<!DOCTYPE>", "<![CDATA>", "<!->", "text & more"
    };

    function automatic logic [20:0] noise_char();
        string marks;
        marks = "<>!?/='\"[]-D C\t\n\r";
        case ($urandom_range(0, 5))
            0: return 21'($urandom_range(0, 21'h1FFFFF));
            1: return 21'($urandom_range(21'h80, 21'hFF));
            2: return 21'hA0;
            3: return 21'($urandom_range(0, 127));
            default: return 21'(marks[$urandom_range(0, marks.len() - 1)]);
        endcase
    endfunction

    // Mostly fragments from the list, a character now and then swapped for noise; the rest noise.
    task automatic queue_random_text(input int count);
        string       frag;
        logic [20:0] c;
        int          n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) < 8) begin
                frag = fragments[$urandom_range(0, $size(fragments) - 1)];
                for (int k = 0; k < frag.len(); k++) begin
                    c = 21'(frag[k]);
                    if ($urandom_range(0, 19) == 0) c = noise_char();
                    char_feed.push_back(c);
                    n++;
                end
            end else begin
                char_feed.push_back(noise_char());
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: offers the next character, idling at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_if.valid <= 1'b0;
            char_if.data  <= '0;
        end else if (!char_if.valid || char_if.ready) begin
            if (char_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                char_if.valid <= 1'b1;
                char_if.data  <= char_feed.pop_front();
            end else begin
                char_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, and one long hold at the start of the last
    // phase so that the scanner fills up and withdraws input ready.
    // ------------------------------------------------------------------
    int hold_left = 0;
    int last_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            last_phase <= phase;
            if (phase == 2 && last_phase != 2) begin
                hold_left       <= HoldCycles;
                result_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left       <= hold_left - 1;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Prediction on accepted characters, checking on accepted results.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_scan_result predicted;
        t_scan_result actual;
        t_scan_result wanted;
        if (i_rst_n) begin
            if (char_if.valid && char_if.ready) begin
                predicted = scan_char(char_if.data, model_state);
                if (directed_typed.size() > 0) begin
                    if (directed_typed.pop_front()) predicted = directed_res.pop_front();
                    else void'(directed_res.pop_front());
                end
                expected_results.push_back(predicted);
            end
            if (result_if.valid && result_if.ready) begin
                actual = result_if.data;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d events=%05h",
                             $time, actual.status, actual.events);
                    error_count++;
                end else begin
                    wanted = expected_results.pop_front();
                    if (actual.status !== wanted.status)
                        begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, wanted.status, actual.status);
                        error_count++;
                    end
                    if (actual.events !== wanted.events) begin
                        $display("%0t: events expected %05h actual %05h",
                                 $time, wanted.events, actual.events);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no request moving on either side.
    always @(posedge i_clk) begin
        if ((char_if.valid && char_if.ready) || (result_if.valid && result_if.ready)
            || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IdleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases.
    // ------------------------------------------------------------------
    initial begin
        model_state = sts_pkg::S_DEF;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            char_feed.push_back(directed_rows[i].ch);
            directed_typed.push_back(directed_rows[i].typed);
            directed_res.push_back(directed_rows[i].res);
        end

        for (int p = 0; p < 3; p++) begin
            phase = p;
            send_idle_pct = (p == 0) ? 28 : (p == 1) ? 58 : 0;
            recv_idle_pct = (p == 0) ? 58 : (p == 1) ? 28 : 0;
            queue_random_text(ItemsPerPhase);
            wait (char_feed.size() == 0);
            @(posedge i_clk);
        end

        wait (char_feed.size() == 0 && !char_if.valid && expected_results.size() == 0);
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/sts_pkg.sv
hdl/sts_stream_if.sv
hdl/sts_classify.sv
hdl/sts_next_state.sv
hdl/sgml_tag_scanner_top.sv
test/sgml_tag_scanner_top_tb.sv
